>>> rtl/i2r_pkg.sv
// Shared types, constants and lookup functions for the integer to Roman numeral converter.
// Used by i2r_front, i2r_fifo, i2r_back and integer_to_roman_numeral. Depends on nothing.
`default_nettype none

package i2r_pkg;

    // Input field width and the largest number that has a numeral.
    localparam int unsigned VALUE_W   = 12;
    localparam int unsigned SYMBOL_W  = 7;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

    // Decimal places. The front works from thousands down to tens.
    localparam logic [1:0] PLACE_ONES      = 2'd0;
    localparam logic [1:0] PLACE_TENS      = 2'd1;
    localparam logic [1:0] PLACE_HUNDREDS  = 2'd2;
    localparam logic [1:0] PLACE_THOUSANDS = 2'd3;

    // Role of a character within one decimal digit.
    localparam logic [1:0] KIND_ONE  = 2'd0;
    localparam logic [1:0] KIND_FIVE = 2'd1;
    localparam logic [1:0] KIND_TEN  = 2'd2;

    // ASCII codes of the numeral characters.
    localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;
    localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4D;

    // One classified number, handed from the front to the back.
    typedef struct packed {
        logic             err;
        logic [3:0][3:0]  digits;
    } entry_t;

    // Multiple k of the weight of a decimal place, wide enough for 9 x 1000.
    function automatic logic [13:0] place_multiple(input logic [1:0] place,
                                                   input logic [3:0] k);
        logic [13:0] weight;
        unique case (place)
            PLACE_THOUSANDS: weight = 14'd1000;
            PLACE_HUNDREDS:  weight = 14'd100;
            PLACE_TENS:      weight = 14'd10;
            default:         weight = 14'd1;
        endcase
        return 14'(weight * {10'd0, k});
    endfunction

    // Number of characters that one decimal digit spells.
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] len;
        unique case (d)
            4'd1, 4'd5:                  len = 3'd1;
            4'd2, 4'd4, 4'd6, 4'd9:      len = 3'd2;
            4'd3, 4'd7:                  len = 3'd3;
            4'd8:                        len = 3'd4;
            default:                     len = 3'd0;
        endcase
        return len;
    endfunction

    // Which character of its place a digit shows at position pos.
    function automatic logic [1:0] digit_kind(input logic [3:0] d, input logic [1:0] pos);
        logic [1:0] kind;
        unique case (d)
            4'd4:             kind = (pos == 2'd0) ? KIND_ONE : KIND_FIVE;
            4'd5:             kind = KIND_FIVE;
            4'd6, 4'd7, 4'd8: kind = (pos == 2'd0) ? KIND_FIVE : KIND_ONE;
            4'd9:             kind = (pos == 2'd0) ? KIND_ONE : KIND_TEN;
            default:          kind = KIND_ONE;
        endcase
        return kind;
    endfunction

    // ASCII character for a role at a decimal place.
    function automatic logic [SYMBOL_W-1:0] place_char(input logic [1:0] place,
                                                       input logic [1:0] kind);
        logic [SYMBOL_W-1:0] sym;
        unique case (place)
            PLACE_ONES:     sym = (kind == KIND_ONE) ? SYM_I :
                                  (kind == KIND_FIVE) ? SYM_V : SYM_X;
            PLACE_TENS:     sym = (kind == KIND_ONE) ? SYM_X :
                                  (kind == KIND_FIVE) ? SYM_L : SYM_C;
            PLACE_HUNDREDS: sym = (kind == KIND_ONE) ? SYM_C :
                                  (kind == KIND_FIVE) ? SYM_D : SYM_M;
            default:        sym = SYM_M;
        endcase
        return sym;
    endfunction

endpackage

`default_nettype wire

>>> rtl/i2r_front.sv
// Front end: accepts a number, flags out-of-range values and splits it into decimal digits.
// Depends on i2r_pkg; pushes one entry_t per number into i2r_fifo.
`default_nettype none

module i2r_front
    import i2r_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [VALUE_W-1:0] s_value,
    output logic                    push,
    output entry_t                  push_entry,
    input  wire logic               full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [1:0]          place_reg, place_next;
    logic [VALUE_W-1:0]  rem_reg, rem_next;
    entry_t              entry_reg, entry_next;
    logic [3:0]          dig;
    logic [13:0]         sub;

    assign s_ready    = (state_reg == ST_IDLE);
    assign push       = (state_reg == ST_PUSH) && !full;
    assign push_entry = entry_reg;

    // One digit per cycle: count how many multiples of the place weight fit.
    always_comb begin
        dig = 4'd0;
        sub = 14'd0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, rem_reg} >= place_multiple(place_reg, 4'(k))) begin
                dig = 4'(k);
                sub = place_multiple(place_reg, 4'(k));
            end
        end
    end

    // Sequencer: accept, three digit steps, hand-off; an out-of-range number skips the digit steps.
    always_comb begin
        state_next = state_reg;
        place_next = place_reg;
        rem_next   = rem_reg;
        entry_next = entry_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    entry_next.digits = '0;
                    rem_next          = s_value;
                    place_next        = PLACE_THOUSANDS;
                    if (s_value == '0 || s_value > VALUE_MAX) begin
                        entry_next.err = 1'b1;
                        state_next     = ST_PUSH;
                    end else begin
                        entry_next.err = 1'b0;
                        state_next     = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                rem_next                     = rem_reg - sub[VALUE_W-1:0];
                entry_next.digits[place_reg] = dig;
                if (place_reg == PLACE_TENS) begin
                    entry_next.digits[PLACE_ONES] = rem_next[3:0];
                    state_next                    = ST_PUSH;
                end else begin
                    place_next = place_reg - 2'd1;
                end
            end
            ST_PUSH: begin
                if (!full) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        place_reg <= place_next;
        rem_reg   <= rem_next;
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> rtl/i2r_fifo.sv
// Two-entry queue of classified numbers between the front and the back.
// Depends on i2r_pkg for entry_t.
`default_nettype none

module i2r_fifo
    import i2r_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output entry_t      pop_entry,
    output logic        empty
);

    entry_t      mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2r_back.sv
// Back end: spells the digits of a queued number as Roman numeral characters, one per beat.
// Depends on i2r_pkg; takes entries from i2r_fifo and drives the result channel.
`default_nettype none

module i2r_back
    import i2r_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire entry_t              pop_entry,
    input  wire logic                empty,
    output logic                     pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [SYMBOL_W-1:0]      m_symbol,
    output logic                     m_last,
    output logic                     m_error
);

    logic [3:0][3:0]       digits_reg, digits_next;
    logic                  err_reg, err_next;
    logic [1:0]            pos_reg, pos_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0]   symbol_reg, symbol_next;
    logic                  last_reg, last_next;
    logic                  error_reg, error_next;

    logic                  busy;
    logic                  advance;
    logic [1:0]            place;
    logic [3:0]            cur;
    logic                  digit_done;
    logic [3:0][3:0]       digits_cleared;

    assign busy    = err_reg || (digits_reg != '0);
    assign advance = busy && (!out_valid_reg || m_ready);
    assign pop     = !busy && !empty;

    assign m_valid  = out_valid_reg;
    assign m_symbol = symbol_reg;
    assign m_last   = last_reg;
    assign m_error  = error_reg;

    // Highest place with a nonzero digit is the one being spelled.
    always_comb begin
        priority if (digits_reg[PLACE_THOUSANDS] != 4'd0) begin
            place = PLACE_THOUSANDS;
        end else if (digits_reg[PLACE_HUNDREDS] != 4'd0) begin
            place = PLACE_HUNDREDS;
        end else if (digits_reg[PLACE_TENS] != 4'd0) begin
            place = PLACE_TENS;
        end else begin
            place = PLACE_ONES;
        end
        cur                   = digits_reg[place];
        digit_done            = ({1'b0, pos_reg} == digit_len(cur) - 3'd1);
        digits_cleared        = digits_reg;
        digits_cleared[place] = 4'd0;
    end

    // Load a new number, or emit the next character into the output register.
    always_comb begin
        digits_next    = digits_reg;
        err_next       = err_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !m_ready;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        if (pop) begin
            digits_next = pop_entry.err ? '0 : pop_entry.digits;
            err_next    = pop_entry.err;
            pos_next    = 2'd0;
        end else if (advance) begin
            out_valid_next = 1'b1;
            if (err_reg) begin
                symbol_next = SYM_NONE;
                last_next   = 1'b1;
                error_next  = 1'b1;
                err_next    = 1'b0;
            end else begin
                symbol_next = place_char(place, digit_kind(cur, pos_reg));
                last_next   = digit_done && (digits_cleared == '0);
                error_next  = 1'b0;
                if (digit_done) begin
                    digits_next = digits_cleared;
                    pos_next    = 2'd0;
                end else begin
                    pos_next = pos_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg    <= '0;
            err_reg       <= 1'b0;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            digits_reg    <= digits_next;
            err_reg       <= err_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        error_reg  <= error_next;
    end

endmodule

`default_nettype wire

>>> rtl/integer_to_roman_numeral.sv
// Integer to Roman numeral converter: one 12-bit number in, its numeral out as ASCII characters,
// one per result beat, the final one marked by m_last. An input of 0 or above 3999 gives a single
// beat with m_symbol 0, m_last and m_error set. The front steps through accept, one digit step each
// for thousands, hundreds and tens, and hand-off into a two-entry queue for an in-range number,
// and through accept and hand-off for an out-of-range one; it waits in hand-off while the queue is
// full, and otherwise takes the next number while the back spells the earlier ones. The back
// first loads a number from the queue and then emits one character per cycle while m_ready is
// high; the longest numeral, that of 3888, has 15 characters. The slower of the two halves sets
// the rate: the back for long numerals, the front for short ones.
// Depends on i2r_pkg, i2r_front, i2r_fifo and i2r_back.
`default_nettype none

module integer_to_roman_numeral
    import i2r_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [VALUE_W-1:0]  s_value,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [SYMBOL_W-1:0]      m_symbol,
    output logic                     m_last,
    output logic                     m_error
);

    logic    push;
    logic    full;
    logic    pop;
    logic    empty;
    entry_t  push_entry;
    entry_t  pop_entry;

    // Accept and split into digits.
    i2r_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    // Queue between the two halves.
    i2r_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    // Spell the numeral.
    i2r_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_entry  (pop_entry),
        .empty      (empty),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_symbol   (m_symbol),
        .m_last     (m_last),
        .m_error    (m_error)
    );

    // An error beat always closes its run and carries no character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_last && (m_symbol == SYM_NONE))
        else $error("error beat without last or with a character");

    // A regular beat always carries a numeral character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error |-> (m_symbol != SYM_NONE))
        else $error("numeral beat with empty symbol");

    // The front never pushes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    // The front is not ready again in the cycle after it accepts a number.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front accepted two numbers back to back");

endmodule

`default_nettype wire

>>> tb/sv/tb_integer_to_roman_numeral.sv
// Self-checking testbench for integer_to_roman_numeral: drives numbers, predicts each numeral's
// character beats in place and checks every output beat against them under random backpressure.
// Depends on i2r_pkg and the integer_to_roman_numeral RTL.
`timescale 1ns / 100ps

module tb_integer_to_roman_numeral;
    import i2r_pkg::*;

    // One predicted output character, tagged with the number that produced it.
    typedef struct {
        logic [VALUE_W-1:0]  number;
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                error;
    } numeral_char_t;

    localparam int unsigned RANDOM_NUMBERS = 430;
    localparam int unsigned IDLE_PERCENT   = 18;
    localparam int unsigned STEP_COUNT     = 13;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_valid  = 1'b0;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value  = '0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    logic [SYMBOL_W-1:0] m_symbol;
    logic                m_last;
    logic                m_error;

    // Numeral steps, largest weight first; a second character of SYM_NONE means a single one.
    int unsigned         step_weight [STEP_COUNT] =
        '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
    logic [SYMBOL_W-1:0] step_first [STEP_COUNT] =
        '{SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X, SYM_L, SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I};
    logic [SYMBOL_W-1:0] step_second [STEP_COUNT] =
        '{SYM_NONE, SYM_M, SYM_NONE, SYM_D, SYM_NONE, SYM_C, SYM_NONE, SYM_L, SYM_NONE,
          SYM_X, SYM_NONE, SYM_V, SYM_NONE};

    logic [VALUE_W-1:0] pending_numbers [$];
    numeral_char_t      expected_chars [$];
    int unsigned        total_numbers  = 0;
    int unsigned        numbers_sent   = 0;
    int unsigned        chars_seen     = 0;
    int unsigned        error_beats    = 0;
    int unsigned        mismatches     = 0;
    int unsigned        cycle_count    = 0;
    logic               steady;

    integer_to_roman_numeral u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_symbol (m_symbol),
        .m_last   (m_last),
        .m_error  (m_error)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Cycle counter that opens a window in which neither side idles.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end
    assign steady = (cycle_count >= 2000) && (cycle_count < 3500);

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Appends a number's Roman numeral, or an error beat if out of range, to the expected beats.
    function automatic void spell_numeral(input logic [VALUE_W-1:0] number);
        int unsigned   remaining;
        int unsigned   count;
        numeral_char_t ch;
        remaining = number;
        count     = 0;
        ch.number = number;
        ch.last   = 1'b0;
        ch.error  = 1'b0;
        if (number == 0 || number > VALUE_MAX) begin
            ch.symbol = SYM_NONE;
            ch.last   = 1'b1;
            ch.error  = 1'b1;
            expected_chars.push_back(ch);
            return;
        end
        for (int s = 0; s < STEP_COUNT; s++) begin
            while (remaining >= step_weight[s] && count < 15) begin
                remaining -= step_weight[s];
                ch.symbol = step_first[s];
                expected_chars.push_back(ch);
                count++;
                if (step_second[s] != SYM_NONE && count < 15) begin
                    ch.symbol = step_second[s];
                    expected_chars.push_back(ch);
                    count++;
                end
            end
        end
        // The final character of the run carries the last flag.
        ch = expected_chars[$];
        ch.last = 1'b1;
        expected_chars[$] = ch;
    endfunction

    // Input driver: presents queued numbers, predicting each one as its beat is accepted.
    always @(posedge aclk) begin : drive_numbers
        logic               next_valid;
        logic [VALUE_W-1:0] next_value;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            next_value = s_value;
            if (s_valid && s_ready) begin
                spell_numeral(s_value);
                numbers_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_numbers.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                next_valid = 1'b1;
                next_value = pending_numbers.pop_front();
            end
            s_valid <= next_valid;
            s_value <= next_value;
        end
    end

    // Output monitor: checks each accepted character beat and drives random backpressure.
    always @(posedge aclk) begin : check_characters
        numeral_char_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                chars_seen++;
                if (m_error) begin
                    error_beats++;
                end
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat symbol %02h last %0b error %0b",
                                              m_symbol, m_last, m_error));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_symbol !== want.symbol) begin
                        report_mismatch($sformatf("number %0d: symbol %02h, expected %02h",
                                                  want.number, m_symbol, want.symbol));
                    end
                    if (m_last !== want.last) begin
                        report_mismatch($sformatf("number %0d: last %0b, expected %0b",
                                                  want.number, m_last, want.last));
                    end
                    if (m_error !== want.error) begin
                        report_mismatch($sformatf("number %0d: error %0b, expected %0b",
                                                  want.number, m_error, want.error));
                    end
                end
            end
            m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Stimulus, reset and end of run.
    initial begin : run_test
        logic [VALUE_W-1:0] directed [23];
        int unsigned pick;
        int unsigned digits [4];
        int unsigned long_digits [3];

        // Extremes, every subtractive pair, out-of-range values and alternating bit patterns.
        directed = '{
            12'd1, 12'd3999, 12'd3888, 12'd0, 12'd4000, 12'd4095, 12'd4, 12'd9, 12'd40,
            12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000, 12'd2048, 12'd1994,
            12'd3, 12'd444, 12'd999, 12'd2730, 12'd1365};
        long_digits = '{3, 7, 8};
        foreach (directed[i]) begin
            pending_numbers.push_back(directed[i]);
        end

        // Mostly in-range numbers, some built from long digits, a few out of range.
        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                pending_numbers.push_back(VALUE_W'($urandom_range(3999, 1)));
            end else if (pick < 95) begin
                digits[0] = $urandom_range(3);
                for (int d = 1; d < 4; d++) begin
                    digits[d] = long_digits[$urandom_range(2)];
                end
                pending_numbers.push_back(VALUE_W'(digits[0] * 1000 + digits[1] * 100 +
                                                   digits[2] * 10 + digits[3]));
            end else if (pick < 97) begin
                pending_numbers.push_back('0);
            end else begin
                pending_numbers.push_back(VALUE_W'($urandom_range(4095, 4000)));
            end
        end
        total_numbers = pending_numbers.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (numbers_sent != total_numbers) @(posedge aclk);
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d expected characters never arrived",
                                      expected_chars.size()));
        end
        $display("Converted %0d numbers into %0d character beats, %0d of them error beats.",
                 numbers_sent, chars_seen, error_beats);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0) begin
            $display("tb_integer_to_roman_numeral passed");
        end else begin
            $display("tb_integer_to_roman_numeral failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("Run timed out after %0d cycles.", cycle_count);
        $display("tb_integer_to_roman_numeral failed");
        $finish;
    end

endmodule
